### rtl/core/kds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kds_pkg
// Shared types and constants of the K-line diagnostic session engine.
// ----------------------------------------------------------------------------
package kds_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ECU_ADDR   = 3'd0,
    CFG_OWN_ADDR   = 3'd1,
    CFG_GEAR_LID   = 3'd2,
    CFG_RPM_LID    = 3'd3,
    CFG_START_SVC  = 3'd4,
    CFG_READ_SVC   = 3'd5
  } cfg_idx_e;

  // register reset values
  localparam logic [7:0] RST_ECU_ADDR  = 8'h11;
  localparam logic [7:0] RST_OWN_ADDR  = 8'hF1;
  localparam logic [7:0] RST_GEAR_LID  = 8'h0B;
  localparam logic [7:0] RST_RPM_LID   = 8'h09;
  localparam logic [7:0] RST_START_SVC = 8'hC1;
  localparam logic [7:0] RST_READ_SVC  = 8'h61;
  localparam logic [7:0] RST_LOCAL_ID  = 8'hB0;

  // request frame constants
  localparam logic [7:0] FMT_START      = 8'h81;
  localparam logic [7:0] SID_START_COMM = 8'h81;
  localparam logic [7:0] FMT_PHYS       = 8'h80;
  localparam logic [7:0] READ_DATA_LEN  = 8'h02;
  localparam logic [7:0] SID_READ_LOCAL = 8'h21;

  // request frame lengths, checksum included
  localparam int unsigned MAX_RUN   = 7;
  localparam int unsigned RUN_W     = 3;
  localparam logic [RUN_W-1:0] START_LEN = 3'd5;
  localparam logic [RUN_W-1:0] READ_LEN  = 3'd7;

  // reply framing
  localparam int unsigned IDX_W      = 9;
  localparam logic [IDX_W-1:0] FRAME_DONE = 9'd511;
  localparam logic [IDX_W-1:0] LEN_EXTRA  = 9'd5;

  // header match bits
  localparam logic [3:0] HM_TARGET  = 4'b0001;
  localparam logic [3:0] HM_SOURCE  = 4'b0010;
  localparam logic [3:0] HM_SERVICE = 4'b0100;
  localparam logic [3:0] HM_LID     = 4'b1000;
  localparam logic [3:0] NEED_IDLE  = 4'b0111;
  localparam logic [3:0] NEED_ALL   = 4'b1111;

  typedef enum logic [1:0] {
    SESS_IDLE    = 2'd0,
    SESS_STARTED = 2'd1,
    SESS_POLLING = 2'd2
  } sess_e;

  typedef struct packed {
    logic [7:0] ecu_address;
    logic [7:0] own_address;
    logic [7:0] gear_local_id;
    logic [7:0] rpm_local_id;
    logic [7:0] start_reply_service;
    logic [7:0] read_reply_service;
  } cfg_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] reply_byte;
    logic       reply_first;
    logic       rpm_nonzero;
    logic       prog_mode_flag;
  } in_word_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] tx_byte;
    logic       fast_init;
    logic       reply_ok;
    logic [1:0] session_now;
    logic       last;
  } out_word_t;

  // verdict from the reply checker for the byte being accepted
  typedef struct packed {
    logic hit;
    logic ok;
  } verdict_t;

endpackage

### rtl/core/kds_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kds_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface kds_in_if;
  import kds_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface kds_out_if;
  import kds_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/kds_reply_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kds_reply_check
// Reply frame tracker: byte index, length, running sum and header checks,
// with the verdict for the closing checksum byte.
// ----------------------------------------------------------------------------
module kds_reply_check (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            byte_en_i,
  input  logic [7:0]      byte_i,
  input  logic            first_i,
  input  kds_pkg::cfg_t   cfg_i,
  input  kds_pkg::sess_e  sess_i,
  output kds_pkg::verdict_t verdict_o
);
  import kds_pkg::*;

  logic [IDX_W-1:0] idx_q, idx_d, idx_e;
  logic [IDX_W-1:0] len_q, len_d, len_e;
  logic [7:0]       sum_q, sum_d, sum_e;
  logic [3:0]       hm_q, hm_d, hm_e;
  logic [3:0]       need;
  logic             at_end;
  logic [7:0]       svc_exp;

  // a first byte restarts the frame
  always_comb begin
    if (first_i) begin
      idx_e = '0;
      len_e = '0;
      sum_e = '0;
      hm_e  = '0;
    end else begin
      idx_e = idx_q;
      len_e = len_q;
      sum_e = sum_q;
      hm_e  = hm_q;
    end
  end

  assign need    = (sess_i == SESS_IDLE) ? NEED_IDLE : NEED_ALL;
  assign svc_exp = (sess_i == SESS_IDLE) ? cfg_i.start_reply_service
                                         : cfg_i.read_reply_service;
  assign at_end  = (idx_e >= 9'd4) && (len_e != '0) && (idx_e == len_e - 9'd1);

  // verdict on the checksum byte
  always_comb begin
    verdict_o.hit = byte_en_i && (idx_e != FRAME_DONE) && at_end;
    verdict_o.ok  = (byte_i == sum_e) && ((hm_e & need) == need);
  end

  // frame tracking
  always_comb begin
    idx_d = idx_e;
    len_d = len_e;
    sum_d = sum_e;
    hm_d  = hm_e;
    if (idx_e != FRAME_DONE) begin
      if (at_end) begin
        idx_d = FRAME_DONE;
      end else begin
        case (idx_e)
          9'd1: if (byte_i == cfg_i.own_address) hm_d = hm_e | HM_TARGET;
          9'd2: if (byte_i == cfg_i.ecu_address) hm_d = hm_e | HM_SOURCE;
          9'd3: len_d = {1'b0, byte_i} + LEN_EXTRA;
          9'd4: if (byte_i == svc_exp) hm_d = hm_e | HM_SERVICE;
          9'd5: begin
            if (byte_i == cfg_i.gear_local_id || byte_i == cfg_i.rpm_local_id) begin
              hm_d = hm_e | HM_LID;
            end
          end
          default: ;
        endcase
        sum_d = sum_e + byte_i;
        idx_d = idx_e + 9'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      len_q <= '0;
      sum_q <= '0;
      hm_q  <= '0;
    end else if (byte_en_i) begin
      idx_q <= idx_d;
      len_q <= len_d;
      sum_q <= sum_d;
      hm_q  <= hm_d;
    end
  end

endmodule

### rtl/core/kline_diag_session_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kline_diag_session_engine
// K-line diagnostic tester: builds start and read-by-local-id request frames
// and checks reply frames, tracking the session idle / started / polling.
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | word
//  in_if   | in  | valid / ready   | mode, reply_byte, reply_first, flags
//  out_if  | out | valid / ready   | kind, tx_byte, fast_init, ok, session, last
//  cfg     | in  | cfg_we_i        | cfg_idx_i, cfg_data_i
//
//  a reply byte is taken; its verdict, if any, shows the next cycle
//  a send word is taken and its 5 or 7 bytes leave the result buffer one per cycle
//  while out_if is ready; the next word is taken as the last byte leaves
//  reset clears session, frame tracking and the buffer and loads the registers
//  output stalls hold the buffer; input words wait while results are pending
module kline_diag_session_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  kds_in_if.sink                        in_if,
  kds_out_if.source                     out_if,
  input  logic                          cfg_we_i,
  input  logic [kds_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [kds_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import kds_pkg::*;

  cfg_t       cfg_q;
  sess_e      sess_q, sess_d;
  logic [7:0] lid_q, lid_d;

  logic [RUN_W-1:0] pend_q, pend_d;
  logic [RUN_W-1:0] pos_q, pos_d;
  logic             kind_q, kind_d;
  logic             ok_q, ok_d;
  logic             fast_q, fast_d;
  logic [1:0]       snow_q, snow_d;
  logic [7:0]       run_q [MAX_RUN];
  logic [7:0]       run_d [MAX_RUN];
  logic             load_run;

  logic       in_acc, out_acc;
  logic       send_en, byte_en;
  verdict_t   verdict;
  logic [7:0] csum;

  assign out_acc = out_if.valid && out_if.ready;
  assign in_if.ready = (pend_q == '0) || ((pend_q == 3'd1) && out_if.ready);
  assign in_acc  = in_if.valid && in_if.ready;
  assign send_en = in_acc && in_if.payload.mode;
  assign byte_en = in_acc && !in_if.payload.mode;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ecu_address         <= RST_ECU_ADDR;
      cfg_q.own_address         <= RST_OWN_ADDR;
      cfg_q.gear_local_id       <= RST_GEAR_LID;
      cfg_q.rpm_local_id        <= RST_RPM_LID;
      cfg_q.start_reply_service <= RST_START_SVC;
      cfg_q.read_reply_service  <= RST_READ_SVC;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ECU_ADDR:  cfg_q.ecu_address         <= cfg_data_i;
        CFG_OWN_ADDR:  cfg_q.own_address         <= cfg_data_i;
        CFG_GEAR_LID:  cfg_q.gear_local_id       <= cfg_data_i;
        CFG_RPM_LID:   cfg_q.rpm_local_id        <= cfg_data_i;
        CFG_START_SVC: cfg_q.start_reply_service <= cfg_data_i;
        CFG_READ_SVC:  cfg_q.read_reply_service  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // reply frame tracker
  kds_reply_check u_reply (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (byte_en),
    .byte_i    (in_if.payload.reply_byte),
    .first_i   (in_if.payload.reply_first),
    .cfg_i     (cfg_q),
    .sess_i    (sess_q),
    .verdict_o (verdict)
  );

  // session and local id choice
  always_comb begin
    sess_d = sess_q;
    lid_d  = lid_q;
    if (send_en) begin
      if (sess_q == SESS_STARTED) begin
        lid_d = cfg_q.gear_local_id;
      end else if (sess_q == SESS_POLLING) begin
        if ((cfg_q.gear_local_id != cfg_q.rpm_local_id) &&
            (in_if.payload.rpm_nonzero || !in_if.payload.prog_mode_flag)) begin
          lid_d = (lid_q == cfg_q.gear_local_id) ? cfg_q.rpm_local_id
                                                 : cfg_q.gear_local_id;
        end
      end
    end
    if (verdict.hit && verdict.ok) begin
      sess_d = (sess_q == SESS_IDLE) ? SESS_STARTED : SESS_POLLING;
    end
  end

  // request frame bytes and checksum
  always_comb begin
    for (int k = 0; k < MAX_RUN; k++) run_d[k] = run_q[k];
    if (sess_q == SESS_IDLE) begin
      run_d[0] = FMT_START;
      run_d[1] = cfg_q.ecu_address;
      run_d[2] = cfg_q.own_address;
      run_d[3] = SID_START_COMM;
      csum = FMT_START + cfg_q.ecu_address + cfg_q.own_address + SID_START_COMM;
      run_d[4] = csum;
    end else begin
      run_d[0] = FMT_PHYS;
      run_d[1] = cfg_q.ecu_address;
      run_d[2] = cfg_q.own_address;
      run_d[3] = READ_DATA_LEN;
      run_d[4] = SID_READ_LOCAL;
      run_d[5] = lid_d;
      csum = FMT_PHYS + cfg_q.ecu_address + cfg_q.own_address + READ_DATA_LEN +
             SID_READ_LOCAL + lid_d;
      run_d[6] = csum;
    end
  end

  // result buffer control
  always_comb begin
    pend_d   = pend_q;
    pos_d    = pos_q;
    kind_d   = kind_q;
    ok_d     = ok_q;
    fast_d   = fast_q;
    snow_d   = snow_q;
    load_run = 1'b0;
    if (out_acc) begin
      pend_d = pend_q - 3'd1;
      pos_d  = pos_q + 3'd1;
    end
    if (send_en) begin
      case (sess_q)
        SESS_IDLE: begin
          load_run = 1'b1;
          pend_d   = START_LEN;
          fast_d   = 1'b1;
        end
        SESS_STARTED, SESS_POLLING: begin
          load_run = 1'b1;
          pend_d   = READ_LEN;
          fast_d   = 1'b0;
        end
        default: ;
      endcase
      if (load_run) begin
        pos_d  = '0;
        kind_d = 1'b0;
        ok_d   = 1'b0;
        snow_d = sess_q;
      end
    end
    if (verdict.hit) begin
      pend_d = 3'd1;
      pos_d  = '0;
      kind_d = 1'b1;
      ok_d   = verdict.ok;
      fast_d = 1'b0;
      snow_d = sess_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sess_q <= SESS_IDLE;
      lid_q  <= RST_LOCAL_ID;
      pend_q <= '0;
      pos_q  <= '0;
      kind_q <= 1'b0;
      ok_q   <= 1'b0;
      fast_q <= 1'b0;
      snow_q <= '0;
    end else begin
      sess_q <= sess_d;
      lid_q  <= lid_d;
      pend_q <= pend_d;
      pos_q  <= pos_d;
      kind_q <= kind_d;
      ok_q   <= ok_d;
      fast_q <= fast_d;
      snow_q <= snow_d;
    end
  end

  // frame byte store
  always_ff @(posedge clk_i) begin
    if (load_run) begin
      for (int k = 0; k < MAX_RUN; k++) run_q[k] <= run_d[k];
    end
  end

  // result word
  assign out_if.valid               = (pend_q != '0);
  assign out_if.payload.out_kind    = kind_q;
  assign out_if.payload.tx_byte     = kind_q ? 8'h00 : run_q[pos_q];
  assign out_if.payload.fast_init   = fast_q && (pos_q == '0);
  assign out_if.payload.reply_ok    = ok_q;
  assign out_if.payload.session_now = snow_q;
  assign out_if.payload.last        = (pend_q == 3'd1);

endmodule

### rtl/core/kds_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kds_checker
// Port-level checks of the session engine, bound to the top level.
// ----------------------------------------------------------------------------
module kds_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                in_mode_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input kds_pkg::out_word_t  out_word_i
);
  import kds_pkg::*;

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // a taken send word always starts a run of request bytes
  a_send_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_mode_i |=> out_valid_i && !out_word_i.out_kind)
    else $error("send word gave no request bytes");

  // no input is taken while a run still has bytes to come
  a_run_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_word_i.last |-> !in_ready_i)
    else $error("input taken in the middle of a run");

  // a run continues after a non-last word leaves
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_word_i.last |=> out_valid_i)
    else $error("run cut short");

  // verdicts are single words and fast init only opens an idle start request
  a_word_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (!out_word_i.out_kind || out_word_i.last) &&
                    (!out_word_i.fast_init ||
                     (!out_word_i.out_kind && out_word_i.session_now == SESS_IDLE)))
    else $error("bad verdict or fast init flag");

endmodule

bind kline_diag_session_engine kds_checker u_kds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .in_mode_i   (in_if.payload.mode),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_word_i  (out_if.payload)
);
